### src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int ELEM_WIDTH_DEF = 16;
   localparam int NUM_SLOTS      = 4;

   // Output slot codes: which quaternion component a lane feeds
   typedef logic [1:0] slot_type;
   localparam slot_type SLOT_W = 2'd0;
   localparam slot_type SLOT_X = 2'd1;
   localparam slot_type SLOT_Y = 2'd2;
   localparam slot_type SLOT_Z = 2'd3;

   // Sideband that travels with each word down the cell chains
   typedef struct packed {
      logic                 valid;
      slot_type             root_slot;  // component that takes root / 2
      logic [NUM_SLOTS-1:0] neg;        // numerator sign per component
   } ctrl_type;

endpackage

### src/rmq_req_if.sv
// ----------------------------------------------------------------------------
// rmq_req_if
// Input channel: one 3x3 matrix word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmq_req_if #(
   parameter int ELEM_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] r00, r01, r02;
   logic signed [ELEM_WIDTH-1:0] r10, r11, r12;
   logic signed [ELEM_WIDTH-1:0] r20, r21, r22;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   output ready);
endinterface

### src/rmq_rsp_if.sv
// ----------------------------------------------------------------------------
// rmq_rsp_if
// Result channel: one quaternion word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmq_rsp_if #(
   parameter int ELEM_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Branch and pivot choice, root argument and signed numerators, registered.
// ----------------------------------------------------------------------------
module rmq_front #(
   parameter int ElemWidth = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [ElemWidth-1:0] m_i [9],
   output rmq_pkg::ctrl_type           ctrl_o,
   output logic [2*ElemWidth-1:0]      rad_o,
   output logic [ElemWidth:0]          mag_o [4]
);
   import rmq_pkg::*;

   localparam int W        = ElemWidth;
   localparam int FracBits = W - 2;
   localparam int SW       = W + 3;

   localparam logic signed [SW-1:0] One = {{(SW-1-FracBits){1'b0}}, 1'b1, {FracBits{1'b0}}};

   logic signed [SW-1:0] e [9];
   logic signed [SW-1:0] trace, arg;
   logic signed [W:0]    num [4];
   logic                 tr_pos, p1, p2;
   logic [W:0]           arg_u;
   slot_type             slot;
   ctrl_type             ctrl_in, ctrl_ff;
   logic [2*W-1:0]       rad_in, rad_ff;
   logic [W:0]           mag_in [4];
   logic [W:0]           mag_ff [4];

   // element index: row * 3 + column
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         e[i] = SW'(m_i[i]);
      end
      trace  = e[0] + e[4] + e[8];
      tr_pos = trace > 0;
      p1     = m_i[4] > m_i[0];
      p2     = m_i[8] > (p1 ? m_i[4] : m_i[0]);
      if (tr_pos) begin
         slot   = SLOT_W;
         arg    = trace + One;
         num[0] = '0;
         num[1] = (W+1)'(e[7] - e[5]);
         num[2] = (W+1)'(e[2] - e[6]);
         num[3] = (W+1)'(e[3] - e[1]);
      end else if (p2) begin
         slot   = SLOT_Z;
         arg    = e[8] - e[0] - e[4] + One;
         num[0] = (W+1)'(e[3] - e[1]);
         num[1] = (W+1)'(e[2] + e[6]);
         num[2] = (W+1)'(e[5] + e[7]);
         num[3] = '0;
      end else if (p1) begin
         slot   = SLOT_Y;
         arg    = e[4] - e[8] - e[0] + One;
         num[0] = (W+1)'(e[2] - e[6]);
         num[1] = (W+1)'(e[1] + e[3]);
         num[2] = '0;
         num[3] = (W+1)'(e[7] + e[5]);
      end else begin
         slot   = SLOT_X;
         arg    = e[0] - e[4] - e[8] + One;
         num[0] = (W+1)'(e[7] - e[5]);
         num[1] = '0;
         num[2] = (W+1)'(e[3] + e[1]);
         num[3] = (W+1)'(e[6] + e[2]);
      end
      // negative argument clamps to zero
      arg_u = (arg > 0) ? arg[W:0] : '0;
      rad_in = {1'b0, arg_u, {FracBits{1'b0}}};
      ctrl_in.valid     = in_valid;
      ctrl_in.root_slot = slot;
      for (int s = 0; s < 4; s++) begin
         ctrl_in.neg[s] = num[s][W];
         mag_in[s]      = num[s][W] ? (W+1)'(-num[s]) : num[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (en) begin
         ctrl_ff.root_slot <= ctrl_in.root_slot;
         ctrl_ff.neg       <= ctrl_in.neg;
         rad_ff            <= rad_in;
         mag_ff            <= mag_in;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign rad_o  = rad_ff;
   assign mag_o  = mag_ff;

endmodule

### src/rmq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One restoring square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
   parameter int ElemWidth = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  rmq_pkg::ctrl_type      ctrl_i,
   input  logic [2*ElemWidth-1:0] rad_i,
   input  logic [ElemWidth:0]     rem_i,
   input  logic [ElemWidth-1:0]   root_i,
   input  logic [ElemWidth:0]     mag_i [4],
   output rmq_pkg::ctrl_type      ctrl_o,
   output logic [2*ElemWidth-1:0] rad_o,
   output logic [ElemWidth:0]     rem_o,
   output logic [ElemWidth-1:0]   root_o,
   output logic [ElemWidth:0]     mag_o [4]
);
   import rmq_pkg::*;

   localparam int W = ElemWidth;

   logic [W+2:0]   cur, trial;
   logic           ge;
   ctrl_type       ctrl_ff;
   logic [2*W-1:0] rad_ff;
   logic [W:0]     rem_in, rem_ff;
   logic [W-1:0]   root_in, root_ff;
   logic [W:0]     mag_ff [4];

   always_comb begin
      cur     = {rem_i, rad_i[2*W-1 -: 2]};
      trial   = {1'b0, root_i, 2'b01};
      ge      = cur >= trial;
      rem_in  = ge ? (W+1)'(cur - trial) : cur[W:0];
      root_in = {root_i[W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff.valid <= ctrl_i.valid;
      end
      if (en) begin
         ctrl_ff.root_slot <= ctrl_i.root_slot;
         ctrl_ff.neg       <= ctrl_i.neg;
         rad_ff            <= {rad_i[2*W-3:0], 2'b00};
         rem_ff            <= rem_in;
         root_ff           <= root_in;
         mag_ff            <= mag_i;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign mag_o  = mag_ff;

endmodule

### src/rmq_div_cell.sv
// ----------------------------------------------------------------------------
// rmq_div_cell
// One restoring divide step on four lanes sharing the divisor 2 * root.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
   parameter int ElemWidth = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  rmq_pkg::ctrl_type      ctrl_i,
   input  logic [ElemWidth-1:0]   root_i,
   input  logic [2*ElemWidth-2:0] num_i [4],
   input  logic [ElemWidth:0]     rem_i [4],
   input  logic [2*ElemWidth-2:0] quot_i [4],
   output rmq_pkg::ctrl_type      ctrl_o,
   output logic [ElemWidth-1:0]   root_o,
   output logic [2*ElemWidth-2:0] num_o [4],
   output logic [ElemWidth:0]     rem_o [4],
   output logic [2*ElemWidth-2:0] quot_o [4]
);
   import rmq_pkg::*;

   localparam int W  = ElemWidth;
   localparam int NB = 2 * W - 1;

   logic [W:0]    dvs;
   logic [W+1:0]  cur [4];
   logic          ge [4];
   logic [W:0]    rem_in [4];
   logic [NB-1:0] quot_in [4];
   logic [NB-1:0] num_in [4];
   ctrl_type      ctrl_ff;
   logic [W-1:0]  root_ff;
   logic [NB-1:0] num_ff [4];
   logic [W:0]    rem_ff [4];
   logic [NB-1:0] quot_ff [4];

   always_comb begin
      dvs = {root_i, 1'b0};
      for (int s = 0; s < 4; s++) begin
         cur[s]     = {rem_i[s], num_i[s][NB-1]};
         ge[s]      = cur[s] >= {1'b0, dvs};
         rem_in[s]  = ge[s] ? (W+1)'(cur[s] - {1'b0, dvs}) : cur[s][W:0];
         quot_in[s] = {quot_i[s][NB-2:0], ge[s]};
         num_in[s]  = {num_i[s][NB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff.valid <= ctrl_i.valid;
      end
      if (en) begin
         ctrl_ff.root_slot <= ctrl_i.root_slot;
         ctrl_ff.neg       <= ctrl_i.neg;
         root_ff           <= root_i;
         num_ff            <= num_in;
         rem_ff            <= rem_in;
         quot_ff           <= quot_in;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign root_o = root_ff;
   assign num_o  = num_ff;
   assign rem_o  = rem_ff;
   assign quot_o = quot_ff;

endmodule

### src/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix (signed Q1.F) to saturated quaternion w, x, y, z.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | word
//  req_ch    | in  | valid / ready      | r00 .. r22, ELEM_WIDTH each
//  rsp_ch    | out | valid / ready      | quat_w .. quat_z, ELEM_WIDTH each
//
//  One word per cycle while the skid register is empty. The path is a front
//  register, ELEM_WIDTH square root cells (one root bit each), then
//  2*ELEM_WIDTH-1 divide cells (one quotient bit each), then the output reg.
//  Reset is synchronous and clears only valid bits; no clearing pass.
//  A stalled rsp_ch parks one word in a skid register; ready drops only
//  while that skid register is full, and the whole chain then holds.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
   parameter int ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   rmq_req_if.sink  req_ch,
   rmq_rsp_if.source rsp_ch
);
   import rmq_pkg::*;

   localparam int W        = ELEM_WIDTH;
   localparam int NB       = 2 * W - 1;
   localparam int FracBits = W - 2;

   localparam logic [W-1:0] SatMax = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SatMin = {1'b1, {(W-1){1'b0}}};

   // chain enable: everything moves unless the skid word is waiting
   logic en;

   logic signed [W-1:0] mat [9];

   // square root chain, index 0 is the front register
   ctrl_type       sq_ctrl [W+1];
   logic [2*W-1:0] sq_rad  [W+1];
   logic [W:0]     sq_rem  [W+1];
   logic [W-1:0]   sq_root [W+1];
   logic [W:0]     sq_mag  [W+1][4];

   // divide chain, index 0 is fed from the last root cell
   ctrl_type      dv_ctrl [NB+1];
   logic [W-1:0]  dv_root [NB+1];
   logic [NB-1:0] dv_num  [NB+1][4];
   logic [W:0]    dv_rem  [NB+1][4];
   logic [NB-1:0] dv_quot [NB+1][4];

   logic [W-1:0] res [4];
   logic [W-1:0] out_in [4];
   logic [W-1:0] out_ff [4];
   logic [W-1:0] skid_ff [4];
   logic         out_valid_in, out_valid_ff;
   logic         skid_full_in, skid_full_ff;
   logic         take, exit_v, load_out, load_skid;

   assign mat = '{req_ch.r00, req_ch.r01, req_ch.r02,
                  req_ch.r10, req_ch.r11, req_ch.r12,
                  req_ch.r20, req_ch.r21, req_ch.r22};

   assign en           = !skid_full_ff;
   assign req_ch.ready = en;

   rmq_front #(.ElemWidth(W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_ch.valid),
      .m_i      (mat),
      .ctrl_o   (sq_ctrl[0]),
      .rad_o    (sq_rad[0]),
      .mag_o    (sq_mag[0])
   );
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar c = 0; c < W; c++) begin : g_sqrt
      rmq_sqrt_cell #(.ElemWidth(W)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .ctrl_i (sq_ctrl[c]),
         .rad_i  (sq_rad[c]),
         .rem_i  (sq_rem[c]),
         .root_i (sq_root[c]),
         .mag_i  (sq_mag[c]),
         .ctrl_o (sq_ctrl[c+1]),
         .rad_o  (sq_rad[c+1]),
         .rem_o  (sq_rem[c+1]),
         .root_o (sq_root[c+1]),
         .mag_o  (sq_mag[c+1])
      );
   end

   // numerator magnitude scaled by 2^F enters the divider
   assign dv_ctrl[0] = sq_ctrl[W];
   assign dv_root[0] = sq_root[W];
   for (genvar s = 0; s < 4; s++) begin : g_div_feed
      assign dv_num[0][s]  = {sq_mag[W][s], {FracBits{1'b0}}};
      assign dv_rem[0][s]  = '0;
      assign dv_quot[0][s] = '0;
   end

   for (genvar c = 0; c < NB; c++) begin : g_div
      rmq_div_cell #(.ElemWidth(W)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .ctrl_i (dv_ctrl[c]),
         .root_i (dv_root[c]),
         .num_i  (dv_num[c]),
         .rem_i  (dv_rem[c]),
         .quot_i (dv_quot[c]),
         .ctrl_o (dv_ctrl[c+1]),
         .root_o (dv_root[c+1]),
         .num_o  (dv_num[c+1]),
         .rem_o  (dv_rem[c+1]),
         .quot_o (dv_quot[c+1])
      );
   end

   // Final assembly: pivot component gets root / 2, the rest get the
   // signed, saturated quotient; a zero root zeroes the quotients.
   always_comb begin
      logic [NB-1:0] q;
      logic          over;
      for (int s = 0; s < 4; s++) begin
         q    = dv_quot[NB][s];
         over = 1'b0;
         if (dv_ctrl[NB].root_slot == slot_type'(s)) begin
            res[s] = {1'b0, dv_root[NB][W-1:1]};
         end else if (dv_root[NB] == '0) begin
            res[s] = '0;
         end else if (dv_ctrl[NB].neg[s]) begin
            over   = (|q[NB-1:W]) || (q[W-1] && (|q[W-2:0]));
            res[s] = over ? SatMin : (~q[W-1:0] + 1'b1);
         end else begin
            over   = |q[NB-1:W-1];
            res[s] = over ? SatMax : q[W-1:0];
         end
      end
   end

   // output register plus one skid word
   always_comb begin
      take         = out_valid_ff && rsp_ch.ready;
      exit_v       = en && dv_ctrl[NB].valid;
      load_out     = 1'b0;
      load_skid    = 1'b0;
      out_in       = res;
      out_valid_in = out_valid_ff;
      skid_full_in = skid_full_ff;
      if (skid_full_ff) begin
         if (take) begin
            out_in       = skid_ff;
            load_out     = 1'b1;
            skid_full_in = 1'b0;
         end
      end else if (exit_v) begin
         if (!out_valid_ff || take) begin
            load_out     = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            load_skid    = 1'b1;
            skid_full_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= out_in;
      end
      if (load_skid) begin
         skid_ff <= res;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.quat_w = out_ff[0];
   assign rsp_ch.quat_x = out_ff[1];
   assign rsp_ch.quat_y = out_ff[2];
   assign rsp_ch.quat_z = out_ff[3];

   // skid word only exists behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid full without output word");

   // a word leaving the chain into a stalled output must park in skid
   a_exit_parks: assert property (@(posedge clock) disable iff (reset)
      (exit_v && out_valid_ff && !rsp_ch.ready) |=> skid_full_ff)
      else $error("word lost at chain exit");

   // skid drains in the cycle the output word is taken
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_full_ff && rsp_ch.ready) |=> (!skid_full_ff && out_valid_ff))
      else $error("skid word not moved to output");

endmodule
